>>> hw/rtl/rpd_pkg.sv
package rpd_pkg;

  typedef enum logic [1:0] {
    KIND_EDGE  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    DIR_DEC  = 2'd0,
    DIR_MID  = 2'd1,
    DIR_INC  = 2'd2,
    DIR_LOSS = 2'd3
  } dir_t;

  typedef enum logic [2:0] {
    REG_PULSE_MIN      = 3'd0,
    REG_PULSE_MAX      = 3'd1,
    REG_PULSE_NEUTRAL  = 3'd2,
    REG_TOLERANCE_BAND = 3'd3,
    REG_LOSS_VALUE     = 3'd4
  } reg_idx_t;

  localparam int CFG_DATA_W = 16;
  localparam int BAND_W     = 10;

  localparam logic [15:0]       PULSE_MIN_RST      = 16'd1000;
  localparam logic [15:0]       PULSE_MAX_RST      = 16'd2000;
  localparam logic [15:0]       PULSE_NEUTRAL_RST  = 16'd1500;
  localparam logic [BAND_W-1:0] TOLERANCE_BAND_RST = 10'd50;
  localparam logic [15:0]       LOSS_VALUE_RST     = 16'd0;

  typedef struct packed {
    logic [15:0]       pulse_min;
    logic [15:0]       pulse_max;
    logic [15:0]       pulse_neutral;
    logic [BAND_W-1:0] band;
    logic [15:0]       loss_value;
  } cfg_t;

  // One read request as handed from the front to the back.
  typedef struct packed {
    logic [31:0] width;
    logic        fresh;
    logic        ch_ok;
  } req_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

endpackage

>>> hw/rtl/rpd_front.sv
module rpd_front #(
  parameter int CHANNELS = 3
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    in_kind,
  input  logic [1:0]    in_channel,
  input  logic          in_level,
  input  logic [31:0]   in_time_us,
  input  rpd_pkg::q_status_t q_status,
  output logic          push,
  output rpd_pkg::req_t push_data
);
  import rpd_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int EXT_W = (CH_W > 2) ? CH_W : 2;

  logic [31:0]     rise_r  [CHANNELS];
  logic [31:0]     width_r [CHANNELS];
  logic [CHANNELS-1:0] fresh_r;

  logic [EXT_W-1:0] ch_ext;
  logic [CH_W-1:0]  ch_idx;
  logic             ch_ok;
  logic             accept;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;
  assign ch_ext   = EXT_W'(in_channel);
  assign ch_idx   = ch_ext[CH_W-1:0];
  assign ch_ok    = (32'(in_channel) < 32'(CHANNELS));

  assign push             = accept && (in_kind == KIND_READ);
  assign push_data.ch_ok  = ch_ok;
  assign push_data.width  = ch_ok ? width_r[ch_idx] : 32'd0;
  assign push_data.fresh  = ch_ok && fresh_r[ch_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        rise_r[i]  <= 32'd0;
        width_r[i] <= 32'd0;
      end
      fresh_r <= '0;
    end else if (accept && ch_ok) begin
      case (in_kind)
        KIND_EDGE: begin
          if (in_level) begin
            rise_r[ch_idx] <= in_time_us;
          end else begin
            width_r[ch_idx] <= in_time_us - rise_r[ch_idx];
            rise_r[ch_idx]  <= 32'd0;
            fresh_r[ch_idx] <= 1'b1;
          end
        end
        KIND_READ, KIND_CLEAR: begin
          fresh_r[ch_idx] <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/rpd_queue.sv
module rpd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rpd_pkg::req_t      push_data,
  input  logic               pop,
  output rpd_pkg::req_t      head,
  output rpd_pkg::q_status_t status
);
  import rpd_pkg::*;

  req_t        slot_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  count_r;
  logic        do_push;
  logic        do_pop;

  assign status.full  = (count_r == 2'd2);
  assign status.valid = (count_r != 2'd0);
  assign head         = slot_r[rd_ptr_r];
  assign do_push      = push && !status.full;
  assign do_pop       = pop && status.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

>>> hw/rtl/rpd_back.sv
module rpd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  rpd_pkg::cfg_t      cfg,
  input  rpd_pkg::req_t      head,
  input  rpd_pkg::q_status_t q_status,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_pulse_value,
  output logic [1:0]         out_direction,
  output logic               out_was_fresh
);
  import rpd_pkg::*;

  logic        valid_r;
  logic [15:0] value_r;
  logic [15:0] value_nxt;
  dir_t        dir_r;
  dir_t        dir_nxt;
  logic        fresh_r;

  logic [32:0] wb;
  logic [32:0] w_ext;
  logic [32:0] max_hi;
  logic [32:0] min_hi;
  logic [32:0] nt_hi;
  logic [32:0] max_ext;
  logic [32:0] min_ext;
  logic [32:0] nt_ext;
  logic        is_loss;
  logic        in_max;
  logic        in_min;
  logic        in_nt;

  // Lower bounds are tested as w + band >= centre, so they never go negative.
  assign w_ext   = {1'b0, head.width};
  assign wb      = w_ext + 33'(cfg.band);
  assign max_ext = 33'(cfg.pulse_max);
  assign min_ext = 33'(cfg.pulse_min);
  assign nt_ext  = 33'(cfg.pulse_neutral);
  assign max_hi  = max_ext + 33'(cfg.band);
  assign min_hi  = min_ext + 33'(cfg.band);
  assign nt_hi   = nt_ext + 33'(cfg.band);

  assign is_loss = !head.ch_ok || (w_ext > max_hi) || (wb < min_ext);
  assign in_max  = (wb >= max_ext) && (w_ext <= max_hi);
  assign in_min  = (wb >= min_ext) && (w_ext <= min_hi);
  assign in_nt   = (wb >= nt_ext) && (w_ext <= nt_hi);

  always_comb begin
    priority if (is_loss) begin
      value_nxt = cfg.loss_value;
      dir_nxt   = DIR_LOSS;
    end else if (in_max) begin
      value_nxt = cfg.pulse_max;
      dir_nxt   = DIR_INC;
    end else if (in_min) begin
      value_nxt = cfg.pulse_min;
      dir_nxt   = DIR_DEC;
    end else if (in_nt) begin
      value_nxt = cfg.pulse_neutral;
      dir_nxt   = DIR_MID;
    end else begin
      value_nxt = head.width[15:0];
      dir_nxt   = (w_ext > nt_ext) ? DIR_INC : DIR_DEC;
    end
  end

  assign pop = q_status.valid && (!valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!valid_r || !out_stall) begin
      valid_r <= q_status.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      value_r <= value_nxt;
      dir_r   <= dir_nxt;
      fresh_r <= head.fresh;
    end
  end

  assign out_valid       = valid_r;
  assign out_pulse_value = value_r;
  assign out_direction   = dir_r;
  assign out_was_fresh   = fresh_r;

endmodule

>>> hw/rtl/rc_pwm_channel_decoder.sv
// An accepted read word is written into the queue and then registered in the output stage.
// One word of any kind (edge, clear or read) is accepted per cycle while the queue is not full (in_stall low).
// A two-word queue between the channel state and the classifier absorbs output stalls.
// Reset is synchronous and active low: it clears all channel timestamps, widths
// and fresh flags, empties the queue and restores the default configuration.
module rc_pwm_channel_decoder #(
  parameter int CHANNELS = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [1:0]  in_channel,
  input  logic        in_level,
  input  logic [31:0] in_time_us,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_pulse_value,
  output logic [1:0]  out_direction,
  output logic        out_was_fresh
);
  import rpd_pkg::*;

  cfg_t      cfg_r;
  req_t      push_data;
  req_t      head;
  q_status_t q_status;
  logic      push;
  logic      pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pulse_min     <= PULSE_MIN_RST;
      cfg_r.pulse_max     <= PULSE_MAX_RST;
      cfg_r.pulse_neutral <= PULSE_NEUTRAL_RST;
      cfg_r.band          <= TOLERANCE_BAND_RST;
      cfg_r.loss_value    <= LOSS_VALUE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PULSE_MIN:      cfg_r.pulse_min     <= cfg_wdata;
        REG_PULSE_MAX:      cfg_r.pulse_max     <= cfg_wdata;
        REG_PULSE_NEUTRAL:  cfg_r.pulse_neutral <= cfg_wdata;
        REG_TOLERANCE_BAND: cfg_r.band          <= cfg_wdata[BAND_W-1:0];
        REG_LOSS_VALUE:     cfg_r.loss_value    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  rpd_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_kind    (in_kind),
    .in_channel (in_channel),
    .in_level   (in_level),
    .in_time_us (in_time_us),
    .q_status   (q_status),
    .push       (push),
    .push_data  (push_data)
  );

  rpd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  rpd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .head            (head),
    .q_status        (q_status),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pulse_value (out_pulse_value),
    .out_direction   (out_direction),
    .out_was_fresh   (out_was_fresh)
  );

  a_full_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    q_status.full |-> q_status.valid)
    else $error("queue full while empty");

  a_read_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_kind == KIND_READ) |=> q_status.valid || out_valid)
    else $error("accepted read word lost");

  a_no_spurious_out: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid && !q_status.valid) |=> !out_valid)
    else $error("output word without queued request");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

>>> tb/sv/rc_pwm_channel_decoder_tb.sv
module rc_pwm_channel_decoder_tb;
  import rpd_pkg::*;

  localparam int CHANNELS     = 3;
  localparam int CYCLE_LIMIT  = 250000;
  localparam int HOLD_CYCLES  = 150;
  localparam int SETTLE_TICKS = 4;

  typedef struct packed {
    logic [15:0] value;
    dir_t        dir;
    logic        fresh;
  } reading_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_kind;
  logic [1:0]  in_channel;
  logic        in_level;
  logic [31:0] in_time_us;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_pulse_value;
  logic [1:0]  out_direction;
  logic        out_was_fresh;

  logic [31:0]       rise_stamp [CHANNELS];
  logic [31:0]       width_held [CHANNELS];
  logic              fresh_held [CHANNELS];
  logic [15:0]       min_w;
  logic [15:0]       max_w;
  logic [15:0]       neutral_w;
  logic [15:0]       loss_w;
  logic [BAND_W-1:0] band_w;

  reading_t pending_readings [$];
  int       mismatches  = 0;
  int       cycles      = 0;
  int       words_sent  = 0;
  int       holds_asked = 0;
  int       holds_done  = 0;
  int       hold_left   = 0;
  bit       quiet       = 1'b0;

  rc_pwm_channel_decoder #(.CHANNELS(CHANNELS)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_channel      (in_channel),
    .in_level        (in_level),
    .in_time_us      (in_time_us),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pulse_value (out_pulse_value),
    .out_direction   (out_direction),
    .out_was_fresh   (out_was_fresh)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("rc_pwm_channel_decoder regression: fail");
      $finish;
    end
  end

  // The receiver stalls at random (never while quiet), or holds off for a long stretch when asked.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_done != holds_asked) begin
      holds_done <= holds_asked;
      hold_left  <= HOLD_CYCLES;
      out_stall  <= 1'b1;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 26);
    end
  end

  task automatic report_mismatch(string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    mismatches++;
  endtask

  always @(posedge clk) begin : check_readings
    reading_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_readings.size() == 0) begin
        report_mismatch($sformatf("unexpected word value=%0d dir=%0d fresh=%0b",
                                  out_pulse_value, out_direction, out_was_fresh));
      end else begin
        want = pending_readings.pop_front();
        if (out_pulse_value !== want.value)
          report_mismatch($sformatf("pulse_value %0d, expected %0d",
                                    out_pulse_value, want.value));
        if (out_direction !== want.dir)
          report_mismatch($sformatf("direction %0d, expected %0d",
                                    out_direction, want.dir));
        if (out_was_fresh !== want.fresh)
          report_mismatch($sformatf("was_fresh %0b, expected %0b",
                                    out_was_fresh, want.fresh));
      end
    end
  end

  function automatic void decode_word(logic [1:0] kind, logic [1:0] ch, logic level,
                                      logic [31:0] stamp);
    reading_t r;
    longint   w;
    longint   b;
    longint   mn;
    longint   mx;
    longint   nt;
    bit       ok;
    ok = (ch < CHANNELS);
    case (kind)
      KIND_EDGE: begin
        if (ok && level) begin
          rise_stamp[ch] = stamp;
        end else if (ok) begin
          width_held[ch] = stamp - rise_stamp[ch];
          rise_stamp[ch] = '0;
          fresh_held[ch] = 1'b1;
        end
      end
      KIND_CLEAR: begin
        if (ok) fresh_held[ch] = 1'b0;
      end
      KIND_READ: begin
        r.value = loss_w;
        r.dir   = DIR_LOSS;
        r.fresh = 1'b0;
        if (ok) begin
          r.fresh = fresh_held[ch];
          fresh_held[ch] = 1'b0;
          w  = width_held[ch];
          b  = band_w;
          mn = min_w;
          mx = max_w;
          nt = neutral_w;
          if (w > mx + b || w < mn - b) begin
            r.value = loss_w;
            r.dir   = DIR_LOSS;
          end else if (w >= mx - b) begin
            r.value = max_w;
            r.dir   = DIR_INC;
          end else if (w >= mn - b && w <= mn + b) begin
            r.value = min_w;
            r.dir   = DIR_DEC;
          end else if (w >= nt - b && w <= nt + b) begin
            r.value = neutral_w;
            r.dir   = DIR_MID;
          end else begin
            r.value = width_held[ch][15:0];
            r.dir   = (w > nt) ? DIR_INC : DIR_DEC;
          end
        end
        pending_readings.push_back(r);
      end
      default: begin
      end
    endcase
  endfunction

  task automatic send_word(logic [1:0] kind, logic [1:0] ch, logic level,
                           logic [31:0] stamp);
    int gap;
    if (!quiet && $urandom_range(99) < 26) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_kind    <= kind;
    in_channel <= ch;
    in_level   <= level;
    in_time_us <= stamp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_word(kind, ch, level, stamp);
    words_sent++;
  endtask

  task automatic send_pulse(logic [1:0] ch, logic [31:0] start, logic [31:0] width);
    send_word(KIND_EDGE, ch, 1'b1, start);
    send_word(KIND_EDGE, ch, 1'b0, start + width);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_PULSE_MIN:      min_w     = data;
      REG_PULSE_MAX:      max_w     = data;
      REG_PULSE_NEUTRAL:  neutral_w = data;
      REG_TOLERANCE_BAND: band_w    = data[BAND_W-1:0];
      REG_LOSS_VALUE:     loss_w    = data;
      default: begin
      end
    endcase
  endtask

  task automatic load_thresholds(logic [15:0] mn, logic [15:0] mx, logic [15:0] nt,
                                 logic [15:0] bd, logic [15:0] lv);
    wait_idle();
    write_reg(REG_PULSE_MIN, mn);
    write_reg(REG_PULSE_MAX, mx);
    write_reg(REG_PULSE_NEUTRAL, nt);
    write_reg(REG_TOLERANCE_BAND, bd);
    write_reg(REG_LOSS_VALUE, lv);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [1:0] any_channel();
    if ($urandom_range(19) == 0) return 2'd3;
    return 2'($urandom_range(CHANNELS - 1));
  endfunction

  function automatic logic [31:0] pick_width();
    longint centre;
    longint off;
    logic [31:0] w;
    off = $urandom_range(2 * band_w + 6);
    off = off - band_w - 3;
    case ($urandom_range(6))
      0: w = 32'(longint'(min_w) + off);
      1: w = 32'(longint'(max_w) + off);
      2: w = 32'(longint'(neutral_w) + off);
      3: w = $urandom_range(70000);
      4: w = $urandom;
      default: begin
        centre = $urandom_range(2500, 500);
        w = 32'(centre);
      end
    endcase
    return w;
  endfunction

  // Widths sit on or just beyond each bound of the current thresholds, then 0 and -1.
  task automatic probe_widths();
    longint b;
    longint marks [14];
    logic [1:0] ch;
    b = band_w;
    marks = '{longint'(min_w) - b - 1, longint'(min_w) - b,
              longint'(min_w) + b, longint'(min_w) + b + 1,
              longint'(neutral_w) - b - 1, longint'(neutral_w) - b,
              longint'(neutral_w) + b, longint'(neutral_w) + b + 1,
              longint'(max_w) - b - 1, longint'(max_w) - b,
              longint'(max_w) + b, longint'(max_w) + b + 1,
              0, -1};
    foreach (marks[i]) begin
      ch = 2'($urandom_range(CHANNELS - 1));
      send_pulse(ch, $urandom, 32'(marks[i]));
      send_word(KIND_READ, ch, 1'($urandom_range(1)), $urandom);
    end
  endtask

  task automatic random_traffic(int count);
    int stop;
    int pick;
    logic [1:0] ch;
    stop = words_sent + count;
    while (words_sent < stop) begin
      pick = $urandom_range(99);
      ch = any_channel();
      if (pick < 72) begin
        send_pulse(ch, $urandom, pick_width());
        if ($urandom_range(3) == 0)
          send_word(KIND_CLEAR, ch, 1'($urandom_range(1)), $urandom);
        send_word(KIND_READ, ch, 1'($urandom_range(1)), $urandom);
        if ($urandom_range(4) == 0)
          send_word(KIND_READ, ch, 1'($urandom_range(1)), $urandom);
      end else if (pick < 84) begin
        send_word(KIND_EDGE, ch, 1'($urandom_range(1)), $urandom);
        send_word(KIND_READ, ch, 1'($urandom_range(1)), $urandom);
      end else begin
        send_word(2'($urandom_range(3)), 2'($urandom_range(3)), 1'($urandom_range(1)),
                  $urandom);
      end
    end
  endtask

  task automatic test_reset_state();
    send_word(KIND_READ, 2'd0, 1'b0, 32'h0000_0000);
    send_word(KIND_READ, 2'd3, 1'b1, 32'hFFFF_FFFF);
  endtask

  task automatic test_directed_pulses();
    send_pulse(2'd0, 32'd100, 32'd1500);
    send_word(KIND_READ, 2'd0, 1'b0, 32'd0);
    send_word(KIND_READ, 2'd0, 1'b0, 32'd0);
    send_pulse(2'd1, 32'hFFFF_FF00, 32'd2048);
    send_word(KIND_READ, 2'd1, 1'b0, 32'd0);
    send_word(KIND_EDGE, 2'd2, 1'b0, 32'd1010);
    send_word(KIND_CLEAR, 2'd2, 1'b0, 32'd0);
    send_word(KIND_READ, 2'd2, 1'b0, 32'd0);
    send_pulse(2'd0, 32'h0000_0000, 32'hFFFF_FFFF);
    send_word(KIND_READ, 2'd0, 1'b1, 32'hFFFF_FFFF);
    send_pulse(2'd1, 32'd5000, 32'd1200);
    send_word(KIND_READ, 2'd1, 1'b0, 32'd0);
    send_pulse(2'd2, 32'd7000, 32'd1800);
    send_word(KIND_READ, 2'd2, 1'b0, 32'd0);
    send_word(KIND_EDGE, 2'd3, 1'b1, 32'd123);
    send_word(KIND_CLEAR, 2'd3, 1'b0, 32'd0);
    send_word(2'd3, 2'd1, 1'b1, 32'hA5A5_5A5A);
    send_word(KIND_READ, 2'd3, 1'b0, 32'd0);
  endtask

  task automatic test_band_edges();
    probe_widths();
  endtask

  task automatic test_config_extremes();
    load_thresholds(16'd0, 16'hFFFF, 16'h8000, 16'hFFFF, 16'hFFFF);
    probe_widths();
    random_traffic(60);
    load_thresholds(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'h5A5A);
    probe_widths();
    random_traffic(60);
    load_thresholds(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    probe_widths();
    random_traffic(60);
  endtask

  task automatic test_random_configs();
    for (int p = 0; p < 5; p++) begin
      if (p % 2 == 0)
        load_thresholds(16'($urandom_range(1200, 800)), 16'($urandom_range(2200, 1800)),
                        16'($urandom_range(1600, 1400)), 16'($urandom_range(120)),
                        16'($urandom));
      else
        load_thresholds(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom));
      quiet = (p == 2);
      random_traffic(300);
      quiet = 1'b0;
    end
  endtask

  task automatic test_backpressure();
    wait_idle();
    quiet = 1'b1;
    holds_asked++;
    for (int i = 0; i < 30; i++) begin
      if (i % 3 == 0) send_pulse(2'($urandom_range(CHANNELS - 1)), $urandom, pick_width());
      send_word(KIND_READ, any_channel(), 1'($urandom_range(1)), $urandom);
    end
    wait_idle();
    quiet = 1'b0;
  endtask

  initial begin
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= REG_PULSE_MIN;
    cfg_wdata  <= '0;
    in_valid   <= 1'b0;
    in_kind    <= KIND_EDGE;
    in_channel <= '0;
    in_level   <= 1'b0;
    in_time_us <= '0;
    out_stall  <= 1'b0;
    min_w      = PULSE_MIN_RST;
    max_w      = PULSE_MAX_RST;
    neutral_w  = PULSE_NEUTRAL_RST;
    band_w     = TOLERANCE_BAND_RST;
    loss_w     = LOSS_VALUE_RST;
    for (int c = 0; c < CHANNELS; c++) begin
      rise_stamp[c] = '0;
      width_held[c] = '0;
      fresh_held[c] = 1'b0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_directed_pulses();
    test_band_edges();
    test_config_extremes();
    test_random_configs();
    test_backpressure();
    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("rc_pwm_channel_decoder regression: pass");
    end else begin
      $display("rc_pwm_channel_decoder regression: fail");
    end
    $finish;
  end

endmodule
